[src/bmorph_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmorph_pkg: shared definitions for the 3x3 binary erosion and dilation block
// Register indexes, reset values, field widths, the pixel classifier and the
// structure that carries the static settings to the result evaluator.
// ----------------------------------------------------------------------------
package bmorph_pkg;

	// Default for the widest image line that the line store holds.
	localparam int DEF_MAX_WIDTH = 1024;

	// Fixed field widths.
	localparam int PIX_W       = 8;
	localparam int ROW_W       = 12;
	localparam int OUT_COL_W   = 10;
	localparam int IMG_W_BITS  = 11;
	localparam int IMG_H_BITS  = 13;
	localparam int MASK_W      = 9;
	localparam int LEVEL_W     = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int MAX_HEIGHT  = 4096;

	// Each pixel is kept as two flags: bit 0 is "equals 0", bit 1 "equals 255".
	localparam int FLAG_W  = 2;
	localparam int COL_F_W = 3 * FLAG_W;
	localparam int WIN_W   = 3 * COL_F_W;
	localparam int STORE_W = 2 * FLAG_W;
	localparam int GRP_N   = 4;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STRUCT_MASK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ON     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OFF    = 3'd4;

	// Reset values of the registers.
	localparam int                   RST_IMAGE_WIDTH  = 640;
	localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [MASK_W-1:0]    RST_STRUCT_MASK  = 9'd186;
	localparam logic [LEVEL_W-1:0]   RST_LEVEL_ON     = 8'd230;
	localparam logic [LEVEL_W-1:0]   RST_LEVEL_OFF    = 8'd25;

	typedef struct packed {
		logic [MASK_W-1:0]  mask;
		logic [LEVEL_W-1:0] level_on;
		logic [LEVEL_W-1:0] level_off;
	} bmorph_levels_t;

	function automatic logic [FLAG_W-1:0] classify(input logic [PIX_W-1:0] p);
		return {p == 8'hFF, p == 8'h00};
	endfunction

endpackage

[src/binary_erode_dilate_3x3_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_erode_dilate_3x3_top: 3x3 binary erosion and dilation of a stream
// Pixels arrive in raster order; each pixel produces up to four results, one
// for every pixel whose clipped 3x3 window it completes.
//
//   Channel  Direction  Handshake             Beat contents
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//   in       in         in_valid/in_ready     pixel
//   out      out        out_valid/out_ready   out_row, out_col, eroded, dilated,
//                                             last_in_group, frame_end
//
// An input beat is accepted in every cycle as long as each pixel produces at
// most one result and the output does not stall; a pixel with more results
// holds the result stage until the single result register has taken each of
// them in turn. A beat passes stage 1, then stage 2, then the result register.
// Reset clears the counters, the window and all valid flags; the line store is
// not cleared, as stale entries are always clipped away. A stalled output
// holds the result register, then the result stage, then the input stage.
// ----------------------------------------------------------------------------
module binary_erode_dilate_3x3_top #(
	parameter int MAX_WIDTH = bmorph_pkg::DEF_MAX_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bmorph_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bmorph_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bmorph_pkg::PIX_W-1:0]        pixel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bmorph_pkg::ROW_W-1:0]        out_row,
	output logic [bmorph_pkg::OUT_COL_W-1:0]    out_col,
	output logic [bmorph_pkg::LEVEL_W-1:0]      eroded,
	output logic [bmorph_pkg::LEVEL_W-1:0]      dilated,
	output logic                                last_in_group,
	output logic                                frame_end
);

	// Column counter and line store address width, and a width that can hold
	// both the largest line and any value of the width register.
	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = ($clog2(MAX_WIDTH + 1) > bmorph_pkg::IMG_W_BITS) ?
		$clog2(MAX_WIDTH + 1) : bmorph_pkg::IMG_W_BITS;

	logic [WW-1:0]                         img_w;
	logic [bmorph_pkg::IMG_H_BITS-1:0]     img_h;
	bmorph_pkg::bmorph_levels_t            levels;

	// Input side: position counters.
	logic                                  in_acc;
	logic [CW-1:0]                         col_q;
	logic [bmorph_pkg::ROW_W-1:0]          row_q;
	logic                                  last_col;
	logic                                  last_row;
	logic [bmorph_pkg::GRP_N-1:0]          grp;

	// Stage 1: the accepted pixel while its line store entry is read.
	logic                                  valid_s1;
	logic [bmorph_pkg::FLAG_W-1:0]         cur_s1;
	logic [CW-1:0]                         col_s1;
	logic [bmorph_pkg::ROW_W-1:0]          row_s1;
	logic [bmorph_pkg::GRP_N-1:0]          pend_s1;
	logic [bmorph_pkg::STORE_W-1:0]        store_rd;
	logic                                  adv_s1;

	// Stage 2: the window and the results still owed by the pixel in it.
	logic [bmorph_pkg::WIN_W-1:0]          window_s2;
	logic [CW-1:0]                         col_s2;
	logic [bmorph_pkg::ROW_W-1:0]          row_s2;
	logic [bmorph_pkg::GRP_N-1:0]          pend_s2;
	logic [bmorph_pkg::GRP_N-1:0]          sel_oh;
	logic [bmorph_pkg::GRP_N-1:0]          pend_rest;
	logic [1:0]                            sel;
	logic                                  emit_go;

	logic [bmorph_pkg::ROW_W-1:0]          res_row;
	logic [CW-1:0]                         res_col;
	logic [bmorph_pkg::LEVEL_W-1:0]        res_ero;
	logic [bmorph_pkg::LEVEL_W-1:0]        res_dil;

	// Configuration writes are always taken; the user must send them only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;

	bmorph_cfg_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.WW        (WW)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.img_w    (img_w),
		.img_h    (img_h),
		.levels   (levels)
	);

	// A counter at or beyond the last index counts as last, so a size made
	// smaller between frames still wraps the counters cleanly.
	assign in_acc   = in_valid & in_ready;
	assign last_col = WW'(col_q) >= (img_w - WW'(1));
	assign last_row = {1'b0, row_q} >= (img_h - 13'd1);

	// Results owed by this pixel, in emission order from bit 0: up-left,
	// up, left, and the pixel itself.
	assign grp[0] = (row_q != '0) && (col_q != '0);
	assign grp[1] = (row_q != '0) && last_col;
	assign grp[2] = last_row && (col_q != '0);
	assign grp[3] = last_row && last_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_s1  <= bmorph_pkg::classify(pixel);
			col_s1  <= col_q;
			row_s1  <= row_q;
			pend_s1 <= grp;
		end
	end

	// The store is read as the pixel is accepted and written back as the pixel
	// leaves stage 1: the lower row moves up and the new pixel becomes the
	// lower row. Neighbouring pixels never share a column, so the write always
	// lands before the same column is read again.
	bmorph_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_store (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (store_rd),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data ({cur_s1, store_rd[bmorph_pkg::STORE_W-1:bmorph_pkg::FLAG_W]})
	);

	// Lowest owed result goes out first; the rest stay for later cycles.
	assign sel_oh    = pend_s2 & (~pend_s2 + 4'd1);
	assign pend_rest = pend_s2 & ~sel_oh;
	assign sel       = {sel_oh[3] | sel_oh[2], sel_oh[3] | sel_oh[1]};
	assign emit_go   = (pend_s2 != '0) && (!out_valid || out_ready);

	// Stage 1 moves on once the window is free, which includes the cycle in
	// which its final result goes to the output register.
	assign adv_s1   = valid_s1 && ((pend_s2 == '0) || (emit_go && (pend_rest == '0)));
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_s2 <= '0;
			pend_s2   <= '0;
		end else if (adv_s1) begin
			// Newest column enters at the top; flags are {current, lower, upper}.
			window_s2 <= {cur_s1, store_rd,
				window_s2[bmorph_pkg::WIN_W-1:bmorph_pkg::COL_F_W]};
			pend_s2   <= pend_s1;
		end else if (emit_go) begin
			pend_s2 <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			col_s2 <= col_s1;
			row_s2 <= row_s1;
		end
	end

	bmorph_eval #(
		.CW (CW),
		.WW (WW)
	) u_eval (
		.window  (window_s2),
		.row     (row_s2),
		.col     (col_s2),
		.sel     (sel),
		.img_w   (img_w),
		.img_h   (img_h),
		.levels  (levels),
		.res_row (res_row),
		.res_col (res_col),
		.eroded  (res_ero),
		.dilated (res_dil)
	);

	// Result register: one beat per cycle to the output channel while out_ready does not stall it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_go) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_row       <= res_row;
			out_col       <= bmorph_pkg::OUT_COL_W'(res_col);
			eroded        <= res_ero;
			dilated       <= res_dil;
			last_in_group <= (pend_rest == '0);
			frame_end     <= sel_oh[3];
		end
	end

endmodule

[src/bmorph_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmorph_cfg_regs: configuration registers
// Holds the image size, already clamped to its legal range, the structuring
// element and the two output levels.
// ----------------------------------------------------------------------------
module bmorph_cfg_regs #(
	parameter int MAX_WIDTH = bmorph_pkg::DEF_MAX_WIDTH,
	parameter int WW        = 11
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [bmorph_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [bmorph_pkg::CFG_DATA_W-1:0]   wr_data,
	output logic [WW-1:0]                       img_w,
	output logic [bmorph_pkg::IMG_H_BITS-1:0]   img_h,
	output bmorph_pkg::bmorph_levels_t          levels
);

	localparam logic [WW-1:0] MAXW  = WW'(MAX_WIDTH);
	localparam int            RST_W = (bmorph_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ?
		MAX_WIDTH : bmorph_pkg::RST_IMAGE_WIDTH;
	localparam logic [bmorph_pkg::IMG_H_BITS-1:0] MAXH =
		bmorph_pkg::IMG_H_BITS'(bmorph_pkg::MAX_HEIGHT);

	logic [WW-1:0]                     raw_w;
	logic [WW-1:0]                     clamp_w;
	logic [bmorph_pkg::IMG_H_BITS-1:0] raw_h;
	logic [bmorph_pkg::IMG_H_BITS-1:0] clamp_h;

	// Sizes are clamped once, at the write, so the datapath sees legal values.
	always_comb begin
		raw_w = WW'(wr_data[bmorph_pkg::IMG_W_BITS-1:0]);
		raw_h = wr_data[bmorph_pkg::IMG_H_BITS-1:0];
		if (raw_w < WW'(2)) begin
			clamp_w = WW'(2);
		end else if (raw_w > MAXW) begin
			clamp_w = MAXW;
		end else begin
			clamp_w = raw_w;
		end
		if (raw_h < 13'd2) begin
			clamp_h = 13'd2;
		end else if (raw_h > MAXH) begin
			clamp_h = MAXH;
		end else begin
			clamp_h = raw_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w            <= WW'(RST_W);
			img_h            <= bmorph_pkg::RST_IMAGE_HEIGHT;
			levels.mask      <= bmorph_pkg::RST_STRUCT_MASK;
			levels.level_on  <= bmorph_pkg::RST_LEVEL_ON;
			levels.level_off <= bmorph_pkg::RST_LEVEL_OFF;
		end else if (wr_en) begin
			case (wr_index)
				bmorph_pkg::CFG_IMAGE_WIDTH: begin
					img_w <= clamp_w;
				end
				bmorph_pkg::CFG_IMAGE_HEIGHT: begin
					img_h <= clamp_h;
				end
				bmorph_pkg::CFG_STRUCT_MASK: begin
					levels.mask <= wr_data[bmorph_pkg::MASK_W-1:0];
				end
				bmorph_pkg::CFG_LEVEL_ON: begin
					levels.level_on <= wr_data[bmorph_pkg::LEVEL_W-1:0];
				end
				bmorph_pkg::CFG_LEVEL_OFF: begin
					levels.level_off <= wr_data[bmorph_pkg::LEVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[src/bmorph_line_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmorph_line_store: flags of the two rows above the current one
// One entry per column holds {lower row flags, upper row flags}. Registered
// read, single write port.
// ----------------------------------------------------------------------------
module bmorph_line_store #(
	parameter int DEPTH = bmorph_pkg::DEF_MAX_WIDTH,
	parameter int AW    = 10
) (
	input  logic                             clk,
	input  logic                             rd_en,
	input  logic [AW-1:0]                    rd_addr,
	output logic [bmorph_pkg::STORE_W-1:0]   rd_data,
	input  logic                             wr_en,
	input  logic [AW-1:0]                    wr_addr,
	input  logic [bmorph_pkg::STORE_W-1:0]   wr_data
);

	logic [bmorph_pkg::STORE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/bmorph_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmorph_eval: erosion and dilation of one result pixel
// Picks the result pixel from the window position code, clips its 3x3
// neighbourhood against the image and reduces the masked flags.
// ----------------------------------------------------------------------------
module bmorph_eval #(
	parameter int CW = 10,
	parameter int WW = 11
) (
	input  logic [bmorph_pkg::WIN_W-1:0]      window,
	input  logic [bmorph_pkg::ROW_W-1:0]      row,
	input  logic [CW-1:0]                     col,
	input  logic [1:0]                        sel,
	input  logic [WW-1:0]                     img_w,
	input  logic [bmorph_pkg::IMG_H_BITS-1:0] img_h,
	input  bmorph_pkg::bmorph_levels_t        levels,
	output logic [bmorph_pkg::ROW_W-1:0]      res_row,
	output logic [CW-1:0]                     res_col,
	output logic [bmorph_pkg::LEVEL_W-1:0]    eroded,
	output logic [bmorph_pkg::LEVEL_W-1:0]    dilated
);

	logic                              oy;
	logic                              ox;
	logic [bmorph_pkg::IMG_H_BITS-1:0] row_ext;
	logic [WW-1:0]                     col_ext;
	logic [2:0]                        row_ok;
	logic [2:0]                        col_ok;
	logic                              hit_zero;
	logic                              hit_full;

	// Bit 1 of the code moves the result down a row, bit 0 right a column.
	assign oy      = sel[1];
	assign ox      = sel[0];
	assign res_row = oy ? row : row - 12'd1;
	assign res_col = ox ? col : col - CW'(1);
	assign row_ext = {1'b0, res_row};
	assign col_ext = WW'(res_col);

	// Neighbour rows and columns at offsets -1, 0 and +1 that lie in the image.
	assign row_ok[0] = (res_row != '0) && (row_ext <= img_h);
	assign row_ok[1] = row_ext < img_h;
	assign row_ok[2] = (row_ext + 13'd1) < img_h;
	assign col_ok[0] = (res_col != '0) && (col_ext <= img_w);
	assign col_ok[1] = col_ext < img_w;
	assign col_ok[2] = (col_ext + WW'(1)) < img_w;

	always_comb begin
		int                         ri;
		int                         ci;
		logic [bmorph_pkg::FLAG_W-1:0] f;
		hit_zero = 1'b0;
		hit_full = 1'b0;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				ri = a + int'(oy);
				ci = b + int'(ox);
				// A neighbour below or right of the newest window edge is not
				// yet in the window; it is never needed by the emission order.
				f = window[((ci > 2 ? 2 : ci) * 6 + (ri > 2 ? 2 : ri) * 2) +: 2];
				if (levels.mask[a*3+b] && row_ok[a] && col_ok[b] && ri <= 2 && ci <= 2)
				begin
					hit_zero = hit_zero | f[0];
					hit_full = hit_full | f[1];
				end
			end
		end
	end

	assign eroded  = hit_zero ? levels.level_off : levels.level_on;
	assign dilated = hit_full ? levels.level_on : levels.level_off;

endmodule
